// File: hdl/sctd_pkg.sv
// Package for the scratchpad CRC temperature decoder: frame positions,
// CRC-8 byte update and the frame result struct.
// No dependencies.
package sctd_pkg;

   localparam int FRAME_BYTES = 9;
   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);
   localparam logic [CNT_W-1:0] POS_TEMP_LSB = CNT_W'(0);
   localparam logic [CNT_W-1:0] POS_TEMP_MSB = CNT_W'(1);
   localparam logic [CNT_W-1:0] POS_REMAIN = CNT_W'(6);

   localparam logic [7:0] EXT_FAMILY = 8'h10;
   localparam logic [7:0] FAMILY_RESET = 8'd40;
   localparam logic [7:0] CRC_POLY_REFLECTED = 8'h8C;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_CRC_FAIL = 1'b1;

   typedef struct packed {
      logic              fire;
      logic              status;
      logic signed [15:0] temperature;
   } frame_result_type;

   // reflected CRC-8, one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFLECTED;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: hdl/sctd_frame.sv
// Frame tracker: byte count, running CRC, captured temperature bytes and
// the result formed on the CRC byte. Uses sctd_pkg.
module sctd_frame import sctd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  logic             frame_restart,
   input  logic [7:0]       family_code,
   output frame_result_type result
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       lsb_ff, lsb_in;
   logic [7:0]       msb_ff, msb_in;
   logic [7:0]       remain_ff, remain_in;

   logic [CNT_W-1:0]   idx;
   logic               last;
   logic signed [14:0] half;
   logic signed [19:0] ext;
   logic signed [15:0] temp_val;

   assign idx  = frame_restart ? '0 : count_ff;
   assign last = (idx >= LAST_IDX);

   always_comb begin
      half = $signed({msb_ff, lsb_ff[7:1]});
      ext  = $signed({half[14], half, 4'b0000}) + 20'sd12 - $signed({12'd0, remain_ff});
      if (family_code != EXT_FAMILY) begin
         temp_val = $signed({msb_ff, lsb_ff});
      end else if (ext > 20'sd32767) begin
         temp_val = 16'sh7FFF;
      end else if (ext < -20'sd32768) begin
         temp_val = -16'sh8000;
      end else begin
         temp_val = ext[15:0];
      end
   end

   always_comb begin
      result.fire = last;
      if (crc_ff != rx_byte) begin
         result.status      = STATUS_CRC_FAIL;
         result.temperature = '0;
      end else begin
         result.status      = STATUS_OK;
         result.temperature = temp_val;
      end
   end

   always_comb begin
      count_in  = count_ff;
      crc_in    = crc_ff;
      lsb_in    = lsb_ff;
      msb_in    = msb_ff;
      remain_in = remain_ff;
      if (step) begin
         if (last) begin
            count_in = '0;
         end else begin
            crc_in   = crc8_byte((idx == '0) ? 8'd0 : crc_ff, rx_byte);
            count_in = idx + CNT_W'(1);
            if (idx == POS_TEMP_LSB) begin
               lsb_in = rx_byte;
            end
            if (idx == POS_TEMP_MSB) begin
               msb_in = rx_byte;
            end
            if (idx == POS_REMAIN) begin
               remain_in = rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         crc_ff    <= '0;
         lsb_ff    <= '0;
         msb_ff    <= '0;
         remain_ff <= '0;
      end else begin
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         lsb_ff    <= lsb_in;
         msb_ff    <= msb_in;
         remain_ff <= remain_in;
      end
   end

endmodule

// File: hdl/scratchpad_crc_temp_decoder.sv
// Scratchpad CRC temperature decoder, top level.
// A request byte is registered in stage s1 and decoded there; the result is
// registered when the ninth byte advances. Throughput: one byte per cycle; the
// input stalls only while a CRC byte waits on a held result.
// Synchronous reset clears the frame state and the valids, and sets
// family_code to 40. Depends on sctd_pkg and sctd_frame.
module scratchpad_crc_temp_decoder import sctd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   input  logic              req_frame_restart,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [15:0] rsp_temperature,
   output logic              rsp_status,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_family_code
);

   logic       family_ff;
   logic [7:0] family_code_ff;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_restart_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_temp_ff;
   logic               rsp_status_ff;

   frame_result_type frame_res;
   logic accept, out_free, s1_advance, emit;

   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && (!frame_res.fire || out_free);
   assign emit       = s1_advance && frame_res.fire;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign accept     = req_valid && !req_stall;

   sctd_frame u_frame (
      .clock         (clock),
      .reset         (reset),
      .step          (s1_advance),
      .rx_byte       (s1_byte_ff),
      .frame_restart (s1_restart_ff),
      .family_code   (family_code_ff),
      .result        (frame_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         family_code_ff <= FAMILY_RESET;
         family_ff      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         family_code_ff <= csr_family_code;
         family_ff      <= 1'b1;
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff    <= req_rx_byte;
         s1_restart_ff <= req_frame_restart;
      end
      if (emit) begin
         rsp_temp_ff   <= frame_res.temperature;
         rsp_status_ff <= frame_res.status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = rsp_temp_ff;
   assign rsp_status      = rsp_status_ff;

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_CRC_FAIL) |-> rsp_temp_ff == 16'sd0)
      else $error("failed CRC result carries a nonzero temperature");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && frame_res.fire && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a pending result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result register overwritten while held");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !s1_valid_ff)
      else $error("valid set right after reset");

   a_csr_seen: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> family_ff)
      else $error("configuration write not taken");

endmodule
